// ===== sv/rssc_pkg.sv =====
// Shared types and codes for the relay switch safety controller.
// No dependencies; imported by rssc_ctrl and the core top level.
package rssc_pkg;

   localparam int TICK_W  = 64;
   localparam int FAULT_W = 16;
   localparam int DELAY_W = 16;

   // item kinds
   localparam logic [1:0] KIND_TICK   = 2'd0;
   localparam logic [1:0] KIND_ACTION = 2'd1;
   localparam logic [1:0] KIND_SENSOR = 2'd2;
   localparam logic [1:0] KIND_FAULT  = 2'd3;

   // host action codes
   localparam logic [2:0] ACT_ENABLE     = 3'd0;
   localparam logic [2:0] ACT_DISABLE    = 3'd1;
   localparam logic [2:0] ACT_CLEAR      = 3'd2;
   localparam logic [2:0] ACT_CONNECT    = 3'd3;
   localparam logic [2:0] ACT_FAST_HV    = 3'd4;
   localparam logic [2:0] ACT_DISCONNECT = 3'd5;

   // device states
   localparam logic [2:0] ST_NONE    = 3'd0;
   localparam logic [2:0] ST_READY   = 3'd1;
   localparam logic [2:0] ST_PROCESS = 3'd2;
   localparam logic [2:0] ST_FAULT   = 3'd3;
   localparam logic [2:0] ST_TRIPPED = 3'd4;

   // switch substates
   localparam logic [1:0] SS_NONE       = 2'd0;
   localparam logic [1:0] SS_START      = 2'd1;
   localparam logic [1:0] SS_START_FAST = 2'd2;
   localparam logic [1:0] SS_WAIT       = 2'd3;

   // error codes
   localparam logic [1:0] ERR_OK        = 2'd0;
   localparam logic [1:0] ERR_BLOCKED   = 2'd1;
   localparam logic [1:0] ERR_BAD_GROUP = 2'd2;
   localparam logic [1:0] ERR_NOT_READY = 2'd3;

   // configuration register indexes
   localparam logic [1:0] CSR_SAFETY_ENABLE = 2'd0;
   localparam logic [1:0] CSR_SETTLE        = 2'd1;
   localparam logic [1:0] CSR_FAST_SETTLE   = 2'd2;

   typedef struct packed {
      logic [1:0]         kind;
      logic [2:0]         action_code;
      logic               group_ok;
      logic               group_fast;
      logic               hv_fast_ok;
      logic               stop_pressed;
      logic               top_present;
      logic               bottom_present;
      logic [FAULT_W-1:0] fault_code;
   } rssc_req_type;

   typedef struct packed {
      logic [2:0]         dev_state;
      logic [1:0]         sub_state;
      logic [1:0]         error_code;
      logic               handled;
      logic               green_led;
      logic               red_led;
      logic               disconnect_all;
      logic               safety_armed;
      logic [FAULT_W-1:0] last_fault;
   } rssc_rsp_type;

endpackage

// ===== sv/relay_switch_safety_controller_core.sv =====
// Relay switch safety controller top level: stream ports, result buffer.
// Depends on rssc_pkg and rssc_ctrl.
//
// One request is taken per clock while req_tready is high and its response is
// registered in the output register or, while that is held, in the skid entry;
// each request yields exactly one response. The controller state advances in the
// cycle a request is accepted, through a single pass of decision logic whose
// longest path is the 64-bit tick increment feeding the deadline add and compare.
// The response side has an output register plus one skid entry, so a request is
// still taken while one response waits; req_tready drops only when both are full.
// Config writes take effect on the next cycle and should be issued idle.
module relay_switch_safety_controller_core
   import rssc_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   // [2:0] action_code, [3] group_ok, [4] group_fast, [5] hv_fast_ok,
   // [6] stop_pressed, [7] top_present, [8] bottom_present, [24:9] fault_code
   input  logic [31:0]        req_tdata,
   // [1:0] kind
   input  logic [1:0]         req_tuser,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   // [2:0] dev_state, [4:3] sub_state, [6:5] error_code, [7] handled,
   // [8] green_led, [9] red_led, [10] disconnect_all, [11] safety_armed,
   // [27:12] last_fault
   output logic [31:0]        rsp_tdata,
   input  logic               csr_we,
   input  logic [1:0]         csr_index,
   input  logic [DELAY_W-1:0] csr_wdata
);

   rssc_req_type item;
   rssc_rsp_type result;
   rssc_rsp_type out_ff, out_in;
   rssc_rsp_type skid_ff, skid_in;
   logic         out_valid_ff, out_valid_in;
   logic         skid_valid_ff, skid_valid_in;
   logic         push;
   logic         pop;

   assign item.kind           = req_tuser;
   assign item.action_code    = req_tdata[2:0];
   assign item.group_ok       = req_tdata[3];
   assign item.group_fast     = req_tdata[4];
   assign item.hv_fast_ok     = req_tdata[5];
   assign item.stop_pressed   = req_tdata[6];
   assign item.top_present    = req_tdata[7];
   assign item.bottom_present = req_tdata[8];
   assign item.fault_code     = req_tdata[24:9];

   assign req_tready = !skid_valid_ff;
   assign push       = req_tvalid && req_tready;
   assign pop        = out_valid_ff && rsp_tready;

   rssc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .accept    (push),
      .item      (item),
      .result    (result)
   );

   always_comb begin
      out_in        = out_ff;
      skid_in       = skid_ff;
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      if (skid_valid_ff) begin
         // skid full: no push possible, drain into the output register
         if (pop) begin
            out_in        = skid_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_in       = result;
         out_valid_in = push;
      end else if (push) begin
         skid_in       = result;
         skid_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {4'd0, out_ff.last_fault, out_ff.safety_armed, out_ff.disconnect_all,
                        out_ff.red_led, out_ff.green_led, out_ff.handled,
                        out_ff.error_code, out_ff.sub_state, out_ff.dev_state};

   a_skid_needs_out: assert property (@(posedge clock) disable iff (reset)
      skid_valid_ff |-> out_valid_ff)
      else $error("skid entry held while output register empty");

   a_push_shows: assert property (@(posedge clock) disable iff (reset)
      push |=> out_valid_ff)
      else $error("accepted request left no response");

   a_armed_not_idle: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.safety_armed |-> out_ff.dev_state != ST_NONE)
      else $error("safety latch armed in state none");

   a_disc_opens: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && out_ff.disconnect_all |->
         (out_ff.dev_state == ST_NONE || !out_ff.red_led))
      else $error("disconnect left connected indicator on");

endmodule

// ===== sv/rssc_ctrl.sv =====
// Device state, LED, latch, tick and settle logic plus the config registers.
// Depends on rssc_pkg. State advances on each accepted request.
module rssc_ctrl
   import rssc_pkg::*;
(
   input  logic                clock,
   input  logic                reset,
   input  logic                csr_we,
   input  logic [1:0]          csr_index,
   input  logic [DELAY_W-1:0]  csr_wdata,
   input  logic                accept,
   input  rssc_req_type        item,
   output rssc_rsp_type        result
);

   logic               safety_enable_ff;
   logic [DELAY_W-1:0] settle_ff;
   logic [DELAY_W-1:0] fast_settle_ff;

   logic [2:0]         main_state_ff, main_state_in;
   logic [1:0]         minor_state_ff, minor_state_in;
   logic               latch_ff, latch_in;
   logic               green_ff, green_in;
   logic               red_ff, red_in;
   logic [FAULT_W-1:0] fault_ff, fault_in;
   logic [TICK_W-1:0]  tick_ff, tick_in;
   logic [TICK_W-1:0]  deadline_ff, deadline_in;

   logic               disc;
   logic [1:0]         err;
   logic               handled;
   logic [DELAY_W-1:0] delay;

   assign delay = (minor_state_ff == SS_START) ? settle_ff : fast_settle_ff;

   always_comb begin
      main_state_in  = main_state_ff;
      minor_state_in = minor_state_ff;
      latch_in       = latch_ff;
      green_in       = green_ff;
      red_in         = red_ff;
      fault_in       = fault_ff;
      tick_in        = tick_ff;
      deadline_in    = deadline_ff;
      disc           = 1'b0;
      err            = ERR_OK;
      handled        = 1'b0;
      case (item.kind)
         KIND_TICK: begin
            tick_in = tick_ff + {{(TICK_W-1){1'b0}}, 1'b1};
            if (main_state_ff == ST_PROCESS) begin
               if (minor_state_ff inside {SS_START, SS_START_FAST}) begin
                  deadline_in    = tick_in + {{(TICK_W-DELAY_W){1'b0}}, delay};
                  minor_state_in = SS_WAIT;
               end else if (minor_state_ff == SS_WAIT && tick_in > deadline_ff) begin
                  main_state_in  = ST_READY;
                  minor_state_in = SS_NONE;
               end
            end
         end
         KIND_ACTION: begin
            handled = 1'b1;
            case (item.action_code)
               ACT_ENABLE: begin
                  if (main_state_ff inside {ST_NONE, ST_TRIPPED}) begin
                     green_in       = 1'b1;
                     main_state_in  = ST_READY;
                     minor_state_in = SS_NONE;
                  end else if (main_state_ff != ST_READY) begin
                     err = ERR_BLOCKED;
                  end
               end
               ACT_DISABLE, ACT_CLEAR: begin
                  // clear fault only acts from the fault state; red led is kept
                  if (item.action_code == ACT_DISABLE || main_state_ff == ST_FAULT) begin
                     fault_in       = '0;
                     disc           = 1'b1;
                     main_state_in  = ST_NONE;
                     minor_state_in = SS_NONE;
                     green_in       = 1'b0;
                     latch_in       = 1'b0;
                  end
               end
               ACT_CONNECT: begin
                  if (main_state_ff inside {ST_READY, ST_TRIPPED}) begin
                     if (item.group_ok) begin
                        red_in   = 1'b1;
                        latch_in = safety_enable_ff;
                        if (!item.group_fast) begin
                           main_state_in  = ST_PROCESS;
                           minor_state_in = SS_START;
                        end
                     end else begin
                        err = ERR_BAD_GROUP;
                     end
                  end else begin
                     err = ERR_NOT_READY;
                  end
               end
               ACT_FAST_HV: begin
                  if (main_state_ff == ST_READY) begin
                     if (item.hv_fast_ok) begin
                        main_state_in  = ST_PROCESS;
                        minor_state_in = SS_START_FAST;
                     end else begin
                        err = ERR_BLOCKED;
                     end
                  end else begin
                     err = ERR_NOT_READY;
                  end
               end
               ACT_DISCONNECT: begin
                  if (main_state_ff inside {ST_READY, ST_TRIPPED}) begin
                     latch_in       = 1'b0;
                     red_in         = 1'b0;
                     disc           = 1'b1;
                     main_state_in  = ST_PROCESS;
                     minor_state_in = SS_START;
                  end else begin
                     err = ERR_NOT_READY;
                  end
               end
               default: begin
                  handled = 1'b0;
               end
            endcase
         end
         KIND_SENSOR: begin
            if (latch_ff && (item.stop_pressed || !item.top_present || !item.bottom_present))
            begin
               latch_in       = 1'b0;
               red_in         = 1'b0;
               disc           = 1'b1;
               main_state_in  = ST_TRIPPED;
               minor_state_in = SS_NONE;
            end
         end
         default: begin
            main_state_in  = ST_FAULT;
            minor_state_in = SS_NONE;
            fault_in       = item.fault_code;
         end
      endcase
   end

   always_comb begin
      result.dev_state      = main_state_in;
      result.sub_state      = minor_state_in;
      result.error_code     = err;
      result.handled        = handled;
      result.green_led      = green_in;
      result.red_led        = red_in;
      result.disconnect_all = disc;
      result.safety_armed   = latch_in;
      result.last_fault     = fault_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         safety_enable_ff <= 1'b0;
         settle_ff        <= DELAY_W'(10);
         fast_settle_ff   <= DELAY_W'(2);
      end else if (csr_we) begin
         case (csr_index)
            CSR_SAFETY_ENABLE: safety_enable_ff <= csr_wdata[0];
            CSR_SETTLE:        settle_ff        <= csr_wdata;
            CSR_FAST_SETTLE:   fast_settle_ff   <= csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         main_state_ff  <= ST_NONE;
         minor_state_ff <= SS_NONE;
         latch_ff       <= 1'b0;
         green_ff       <= 1'b0;
         red_ff         <= 1'b0;
         fault_ff       <= '0;
         tick_ff        <= '0;
         deadline_ff    <= '0;
      end else if (accept) begin
         main_state_ff  <= main_state_in;
         minor_state_ff <= minor_state_in;
         latch_ff       <= latch_in;
         green_ff       <= green_in;
         red_ff         <= red_in;
         fault_ff       <= fault_in;
         tick_ff        <= tick_in;
         deadline_ff    <= deadline_in;
      end
   end

endmodule
